>>> design/fse_pkg.sv
`default_nettype none

package fse_pkg;

  // sizes of the graph
  localparam int MaxNodes = 256;
  localparam int MaxEdges = 64;

  localparam int NodeW  = 8;
  localparam int WtW    = 32;
  localparam int SlotW  = $clog2(MaxEdges);
  localparam int LinkW  = SlotW + 1;
  localparam int TotalW = SlotW + 1;
  localparam int CfgW   = 9;

  // all ones in the link field marks the end of a chain
  localparam logic [LinkW-1:0] NoLink = '1;

  localparam logic [CfgW-1:0] NodeCountReset = CfgW'(MaxNodes);

  // input command codes
  localparam logic [1:0] CmdAdd  = 2'd0;
  localparam logic [1:0] CmdList = 2'd1;
  localparam logic [1:0] CmdDump = 2'd2;

  // status codes
  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatBadNode = 2'd1;
  localparam logic [1:0] StatFull    = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_LIST,
    OP_DUMP,
    OP_BAD_NODE
  } op_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_HEAD,
    ST_EDGE
  } back_state_e;

  // classified word handed from front to back
  typedef struct packed {
    op_kind_e                kind;
    logic [NodeW-1:0]        src;
    logic [NodeW-1:0]        dst;
    logic signed [WtW-1:0]   wt;
  } fse_op_t;

  // one entry of the edge store
  typedef struct packed {
    logic [LinkW-1:0]        link;
    logic signed [WtW-1:0]   wt;
    logic [NodeW-1:0]        dst;
    logic [NodeW-1:0]        src;
  } edge_entry_t;

  localparam int EntryW = $bits(edge_entry_t);

  // one result word
  typedef struct packed {
    logic                    last;
    logic [1:0]              status;
    logic                    is_empty;
    logic signed [LinkW-1:0] next_slot;
    logic [SlotW-1:0]        edge_slot;
    logic signed [WtW-1:0]   wt;
    logic [NodeW-1:0]        dst;
    logic [NodeW-1:0]        src;
  } fse_result_t;

endpackage

`default_nettype wire

>>> design/forward_star_edge_store.sv
// channel   direction  contents
// s_axis    in         tuser: command[1:0]; tdata: source, target, weight
// m_axis    out        tdata: edge, slot, next; tuser: empty, status; tlast
// cfg       in         cfg_data_i: node count, no index
//
// an add does one head table read, then the writes and the result word
// list and dump walks give one word a cycle while the output is not stalled, set by the edge store read port
// the walk starts after the head read (list) or at once (dump)
// reset clears head valid bits and the edge count at once, no clearing pass
// a stalled output holds the walk; the two-entry queue keeps taking words meanwhile until it is full
`default_nettype none

module forward_star_edge_store (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [8:0]  cfg_data_i,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // source_node[7:0], target_node[15:8], edge_weight[47:16]
  input  wire logic [1:0]  s_axis_tuser,  // command[1:0]
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,  // out_source[7:0], out_target[15:8], out_weight[47:16],
                                          // edge_slot[53:48], next_slot[60:54], zero[63:61]
  output logic [2:0]       m_axis_tuser,  // is_empty[0], status[2:1]
  output logic             m_axis_tlast   // last_result
);
  import fse_pkg::*;

  logic        q_push, q_ready, q_valid, q_pop;
  fse_op_t     q_in, q_out;
  fse_result_t res;

  assign cfg_ready_o = 1'b1;

  // front: node count and classification
  fse_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_cmd_i    (s_axis_tuser),
    .in_src_i    (s_axis_tdata[7:0]),
    .in_dst_i    (s_axis_tdata[15:8]),
    .in_wt_i     (s_axis_tdata[47:16]),
    .q_ready_i   (q_ready),
    .in_ready_o  (s_axis_tready),
    .q_push_o    (q_push),
    .q_op_o      (q_in)
  );

  // queue between front and back
  fse_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_op_i (q_in),
    .ready_o   (q_ready),
    .valid_o   (q_valid),
    .op_o      (q_out),
    .pop_i     (q_pop)
  );

  // back: stores, walks and the output register
  fse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (q_valid),
    .op_i        (q_out),
    .op_pop_o    (q_pop),
    .res_valid_o (m_axis_tvalid),
    .res_o       (res),
    .res_ready_i (m_axis_tready)
  );

  // result packing
  assign m_axis_tdata = {3'b000, res.next_slot, res.edge_slot, res.wt, res.dst, res.src};
  assign m_axis_tuser = {res.status, res.is_empty};
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

>>> design/fse_ram.sv
`default_nettype none

module fse_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> design/fse_front.sv
`default_nettype none

module fse_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_valid_i,
  input  wire logic [fse_pkg::CfgW-1:0] cfg_data_i,
  input  wire logic                     in_valid_i,
  input  wire logic [1:0]               in_cmd_i,
  input  wire logic [fse_pkg::NodeW-1:0] in_src_i,
  input  wire logic [fse_pkg::NodeW-1:0] in_dst_i,
  input  wire logic signed [fse_pkg::WtW-1:0] in_wt_i,
  input  wire logic                     q_ready_i,
  output logic                          in_ready_o,
  output logic                          q_push_o,
  output fse_pkg::fse_op_t              q_op_o
);
  import fse_pkg::*;

  logic [CfgW-1:0] node_count_q;
  logic            src_ok;
  logic            dst_ok;
  logic            drop;

  // node count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NodeCountReset;
    end else if (cfg_valid_i) begin
      node_count_q <= cfg_data_i;
    end
  end

  // node range checks
  assign src_ok = (CfgW'(in_src_i) < node_count_q) && (32'(in_src_i) < MaxNodes);
  assign dst_ok = (CfgW'(in_dst_i) < node_count_q) && (32'(in_dst_i) < MaxNodes);

  // classify the incoming word
  always_comb begin
    q_op_o.src = in_src_i;
    q_op_o.dst = in_dst_i;
    q_op_o.wt  = in_wt_i;
    drop       = 1'b0;
    unique case (in_cmd_i)
      CmdAdd:  q_op_o.kind = (src_ok && dst_ok) ? OP_ADD : OP_BAD_NODE;
      CmdList: q_op_o.kind = src_ok ? OP_LIST : OP_BAD_NODE;
      CmdDump: q_op_o.kind = OP_DUMP;
      default: begin
        q_op_o.kind = OP_DUMP;
        drop        = 1'b1;
      end
    endcase
  end

  // unused codes are taken and dropped
  assign in_ready_o = q_ready_i;
  assign q_push_o   = in_valid_i && q_ready_i && !drop;

endmodule

`default_nettype wire

>>> design/fse_queue.sv
`default_nettype none

module fse_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire fse_pkg::fse_op_t push_op_i,
  output logic                  ready_o,
  output logic                  valid_o,
  output fse_pkg::fse_op_t      op_o,
  input  wire logic             pop_i
);
  import fse_pkg::*;

  fse_op_t    mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign op_o    = mem_q[rptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // two-entry ring
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/fse_back.sv
`default_nettype none

module fse_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             op_valid_i,
  input  wire fse_pkg::fse_op_t op_i,
  output logic                  op_pop_o,
  output logic                  res_valid_o,
  output fse_pkg::fse_result_t  res_o,
  input  wire logic             res_ready_i
);
  import fse_pkg::*;

  back_state_e       state_q, state_d;
  fse_op_t           op_q;
  logic              load_op;
  logic              is_list_q, is_list_d;
  logic [SlotW-1:0]  cur_q, cur_d;
  logic [TotalW-1:0] total_q, total_d;
  logic [MaxNodes-1:0] valid_q;
  logic              set_valid;
  logic              out_valid_q;
  fse_result_t       out_q, res_d;
  logic              emit;
  logic              out_free;

  logic [NodeW-1:0]  head_raddr;
  logic [LinkW-1:0]  head_rdata;
  logic [LinkW-1:0]  head_link;
  logic [SlotW-1:0]  edge_raddr;
  logic [EntryW-1:0] edge_rdata;
  edge_entry_t       entry;
  edge_entry_t       new_entry;
  logic              we;
  logic              walk_last;
  logic [SlotW-1:0]  walk_next;

  // head table, a never-written node reads as no edge
  fse_ram #(.Width(LinkW), .Depth(MaxNodes)) u_head (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (op_q.src),
    .wdata_i (LinkW'(total_q)),
    .raddr_i (head_raddr),
    .rdata_o (head_rdata)
  );

  // edge store
  fse_ram #(.Width(EntryW), .Depth(MaxEdges)) u_edges (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (total_q[SlotW-1:0]),
    .wdata_i (new_entry),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rdata)
  );

  assign entry     = edge_rdata;
  assign head_link = valid_q[op_q.src] ? head_rdata : NoLink;
  assign out_free  = !out_valid_q || res_ready_i;

  always_comb begin
    new_entry.src  = op_q.src;
    new_entry.dst  = op_q.dst;
    new_entry.wt   = op_q.wt;
    new_entry.link = head_link;
  end

  // end of walk and next slot
  always_comb begin
    if (is_list_q) begin
      walk_last = (entry.link == NoLink) || (TotalW'(entry.link) >= total_q);
      walk_next = entry.link[SlotW-1:0];
    end else begin
      walk_last = ((TotalW'(cur_q) + TotalW'(1)) == total_q);
      walk_next = cur_q + SlotW'(1);
    end
  end

  // sequencer: next state and outputs
  always_comb begin
    state_d    = state_q;
    is_list_d  = is_list_q;
    cur_d      = cur_q;
    total_d    = total_q;
    op_pop_o   = 1'b0;
    load_op    = 1'b0;
    emit       = 1'b0;
    we         = 1'b0;
    set_valid  = 1'b0;
    head_raddr = op_q.src;
    edge_raddr = cur_q;
    res_d.src       = '0;
    res_d.dst       = '0;
    res_d.wt        = '0;
    res_d.edge_slot = '0;
    res_d.next_slot = NoLink;
    res_d.is_empty  = 1'b0;
    res_d.status    = StatOk;
    res_d.last      = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        head_raddr = op_i.src;
        if (op_valid_i) begin
          unique case (op_i.kind)
            OP_BAD_NODE: begin
              res_d.status = StatBadNode;
              if (out_free) begin
                emit     = 1'b1;
                op_pop_o = 1'b1;
              end
            end
            OP_ADD: begin
              if (total_q == TotalW'(MaxEdges)) begin
                res_d.status = StatFull;
                if (out_free) begin
                  emit     = 1'b1;
                  op_pop_o = 1'b1;
                end
              end else begin
                op_pop_o = 1'b1;
                load_op  = 1'b1;
                state_d  = ST_ADD;
              end
            end
            OP_LIST: begin
              op_pop_o = 1'b1;
              load_op  = 1'b1;
              state_d  = ST_HEAD;
            end
            OP_DUMP: begin
              if (total_q == '0) begin
                res_d.is_empty = 1'b1;
                if (out_free) begin
                  emit     = 1'b1;
                  op_pop_o = 1'b1;
                end
              end else begin
                op_pop_o   = 1'b1;
                load_op    = 1'b1;
                is_list_d  = 1'b0;
                cur_d      = '0;
                edge_raddr = '0;
                state_d    = ST_EDGE;
              end
            end
            default: op_pop_o = 1'b1;
          endcase
        end
      end
      ST_ADD: begin
        res_d.src       = op_q.src;
        res_d.dst       = op_q.dst;
        res_d.wt        = op_q.wt;
        res_d.edge_slot = total_q[SlotW-1:0];
        res_d.next_slot = head_link;
        if (out_free) begin
          emit      = 1'b1;
          we        = 1'b1;
          set_valid = 1'b1;
          total_d   = total_q + TotalW'(1);
          state_d   = ST_IDLE;
        end
      end
      ST_HEAD: begin
        if ((head_link == NoLink) || (TotalW'(head_link) >= total_q)) begin
          res_d.is_empty = 1'b1;
          if (out_free) begin
            emit    = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          is_list_d  = 1'b1;
          cur_d      = head_link[SlotW-1:0];
          edge_raddr = head_link[SlotW-1:0];
          state_d    = ST_EDGE;
        end
      end
      ST_EDGE: begin
        res_d.src       = entry.src;
        res_d.dst       = entry.dst;
        res_d.wt        = entry.wt;
        res_d.edge_slot = cur_q;
        res_d.next_slot = entry.link;
        res_d.last      = walk_last;
        if (out_free) begin
          emit = 1'b1;
          if (walk_last) begin
            state_d = ST_IDLE;
          end else begin
            cur_d      = walk_next;
            edge_raddr = walk_next;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      total_q     <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      is_list_q   <= 1'b0;
      cur_q       <= '0;
    end else begin
      state_q   <= state_d;
      total_q   <= total_d;
      is_list_q <= is_list_d;
      cur_q     <= cur_d;
      if (set_valid) valid_q[op_q.src] <= 1'b1;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (load_op) op_q  <= op_i;
    if (emit)    out_q <= res_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

`default_nettype wire

>>> design/fse_checker.sv
`default_nettype none

module fse_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);
  import fse_pkg::*;

  // a stalled word stays offered
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  // a stalled word keeps its contents
  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result word changed while stalled");

  // an error ends the command at once with no link
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[2:1] != StatOk) |->
      m_axis_tlast && (m_axis_tdata[60:54] == NoLink) && !m_axis_tuser[0])
    else $error("error word not final or carries a link");

  // an empty report is a single ok word
  a_empty_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tlast && (m_axis_tuser[2:1] == StatOk) && (m_axis_tdata[53:0] == 54'd0))
    else $error("empty word malformed");

endmodule

bind forward_star_edge_store fse_checker u_fse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
